// File: rtl/gdad_pkg.sv
// Package for the Gregorian date adder: field widths, calendar tables,
// leap-year helpers and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

   localparam int DAY_W   = 5;
   localparam int MON_W   = 4;
   localparam int YEAR_W  = 14;
   localparam int ADD_W   = 16;
   // day-of-year values reach 366
   localparam int DOY_W   = 9;
   // working year may run past the 14-bit field before it wraps on output
   localparam int EYEAR_W = YEAR_W + 1;
   // year modulo 400, kept as a running residue
   localparam int RES_W   = YEAR_W;

   localparam int YEAR_CYCLE   = 400;
   localparam int REDUCE_STEPS = 6;
   localparam int SHIFT_W      = 3;

   localparam logic [MON_W-1:0] MONTH_JAN = MON_W'(1);
   localparam logic [MON_W-1:0] MONTH_FEB = MON_W'(2);
   localparam logic [MON_W-1:0] MONTH_DEC = MON_W'(12);

   typedef struct packed {
      logic                 load;
      logic                 reduce;
      logic [SHIFT_W-1:0]   shift;
      logic                 calc_doy;
      logic                 span;
      logic                 year_step;
      logic                 month_step;
      logic                 load_rsp;
   } cmd_type;

   typedef struct packed {
      logic fits_year;
      logic past_year;
      logic month_done;
   } sts_type;

   // leap test from the year modulo 400
   function automatic logic leap_res(input logic [DOY_W-1:0] r);
      leap_res = (r[1:0] == 2'b00) && (r != DOY_W'(100)) && (r != DOY_W'(200))
                 && (r != DOY_W'(300));
   endfunction

   function automatic logic [DOY_W-1:0] year_len(input logic leap);
      year_len = leap ? DOY_W'(366) : DOY_W'(365);
   endfunction

   // days before the first of each month in a common year
   function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
      case (m)
         4'd1:    days_before = DOY_W'(0);
         4'd2:    days_before = DOY_W'(31);
         4'd3:    days_before = DOY_W'(59);
         4'd4:    days_before = DOY_W'(90);
         4'd5:    days_before = DOY_W'(120);
         4'd6:    days_before = DOY_W'(151);
         4'd7:    days_before = DOY_W'(181);
         4'd8:    days_before = DOY_W'(212);
         4'd9:    days_before = DOY_W'(243);
         4'd10:   days_before = DOY_W'(273);
         4'd11:   days_before = DOY_W'(304);
         4'd12:   days_before = DOY_W'(334);
         default: days_before = DOY_W'(0);
      endcase
   endfunction

   function automatic logic [DOY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
      case (m)
         4'd2:                   month_len = leap ? DOY_W'(29) : DOY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11: month_len = DOY_W'(30);
         default:                month_len = DOY_W'(31);
      endcase
   endfunction

endpackage

`default_nettype wire

// File: rtl/gdad_req_if.sv
// Request channel of the Gregorian date adder: valid/ready plus start date fields.
// Depends on gdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gdad_req_if;
   logic                          valid;
   logic                          ready;
   logic [gdad_pkg::DAY_W-1:0]    start_day;
   logic [gdad_pkg::MON_W-1:0]    start_month;
   logic [gdad_pkg::YEAR_W-1:0]   start_year;
   logic [gdad_pkg::ADD_W-1:0]    days_to_add;

   modport source (output valid, start_day, start_month, start_year, days_to_add,
                   input ready);
   modport sink (input valid, start_day, start_month, start_year, days_to_add,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/gdad_rsp_if.sv
// Response channel of the Gregorian date adder: valid/ready plus end date fields.
// Depends on gdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gdad_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gdad_pkg::DAY_W-1:0]    end_day;
   logic [gdad_pkg::MON_W-1:0]    end_month;
   logic [gdad_pkg::YEAR_W-1:0]   end_year;

   modport source (output valid, end_day, end_month, end_year, input ready);
   modport sink (input valid, end_day, end_month, end_year, output ready);
endinterface

`default_nettype wire

// File: rtl/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: controller plus datapath on
// valid/ready request and response channels.
// Depends on gdad_pkg, gdad_req_if, gdad_rsp_if, gdad_ctrl, gdad_dpath.
//
//   channel  dir  handshake     payload
//   req_if   in   valid/ready   start_day, start_month, start_year, days_to_add
//   rsp_if   out  valid/ready   end_day, end_month, end_year
//
// One request at a time: the request is accepted, the year is reduced mod 400,
// then the day of year and the rest of the start year are computed, whole
// years are stepped one at a time, months are walked, and the response register
// is loaded. Synchronous active-high reset clears the controller. A new request
// is taken while a result waits on rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_add_days (
   input wire logic   clock,
   input wire logic   reset,
   gdad_req_if.sink   req_if,
   gdad_rsp_if.source rsp_if
);
   import gdad_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // arithmetic and storage
   gdad_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .start_day   (req_if.start_day),
      .start_month (req_if.start_month),
      .start_year  (req_if.start_year),
      .days_to_add (req_if.days_to_add),
      .end_day     (rsp_if.end_day),
      .end_month   (rsp_if.end_month),
      .end_year    (rsp_if.end_year)
   );

endmodule

`default_nettype wire

// File: rtl/gdad_ctrl.sv
// Controller of the Gregorian date adder: sequences residue reduction,
// day-of-year, year and month steps, and owns the response valid flag.
// Depends on gdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdad_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output gdad_pkg::cmd_type      cmd,
   input  wire gdad_pkg::sts_type sts
);
   import gdad_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_DOY    = 3'd2;
   localparam logic [2:0] ST_SPAN   = 3'd3;
   localparam logic [2:0] ST_YEARS  = 3'd4;
   localparam logic [2:0] ST_MONTHS = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   localparam logic [SHIFT_W-1:0] SHIFT_TOP = SHIFT_W'(REDUCE_STEPS - 1);

   logic [2:0]         state_ff, state_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               out_full_ff, out_full_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      shift_in    = shift_ff;
      out_full_in = out_full_ff && !rsp_ready;
      cmd         = '0;
      cmd.shift   = shift_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               shift_in = SHIFT_TOP;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (shift_ff == '0) begin
               state_in = ST_DOY;
            end else begin
               shift_in = shift_ff - SHIFT_W'(1);
            end
         end
         ST_DOY: begin
            cmd.calc_doy = 1'b1;
            state_in     = ST_SPAN;
         end
         ST_SPAN: begin
            cmd.span = 1'b1;
            state_in = sts.fits_year ? ST_MONTHS : ST_YEARS;
         end
         ST_YEARS: begin
            cmd.year_step = 1'b1;
            if (!sts.past_year) begin
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            cmd.month_step = 1'b1;
            if (sts.month_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_full_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               out_full_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         shift_ff    <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         shift_ff    <= shift_in;
         out_full_ff <= out_full_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_full_ff;

   // a finished result is never dropped while the response register is full
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!out_full_ff || rsp_ready))
      else $error("response register overwritten");

   // a loaded response is presented in the next cycle
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("response not presented after load");

   // reduction always runs the full number of steps before day of year
   a_reduce_len: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_doy |-> ($past(cmd.reduce) && $past(cmd.shift) == '0))
      else $error("residue reduction cut short");

endmodule

`default_nettype wire

// File: rtl/gdad_dpath.sv
// Datapath of the Gregorian date adder: request registers, year-mod-400 residue,
// day-of-year arithmetic, year and month stepping, response registers.
// Depends on gdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdad_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gdad_pkg::cmd_type             cmd,
   output gdad_pkg::sts_type                  sts,
   input  wire logic [gdad_pkg::DAY_W-1:0]    start_day,
   input  wire logic [gdad_pkg::MON_W-1:0]    start_month,
   input  wire logic [gdad_pkg::YEAR_W-1:0]   start_year,
   input  wire logic [gdad_pkg::ADD_W-1:0]    days_to_add,
   output logic [gdad_pkg::DAY_W-1:0]         end_day,
   output logic [gdad_pkg::MON_W-1:0]         end_month,
   output logic [gdad_pkg::YEAR_W-1:0]        end_year
);
   import gdad_pkg::*;

   logic [DAY_W-1:0]   day_ff;
   logic [MON_W-1:0]   mon_ff;
   logic [ADD_W-1:0]   add_ff;
   logic [EYEAR_W-1:0] year_ff;
   logic [RES_W-1:0]   res_ff;
   logic [DOY_W-1:0]   doy_ff;
   logic [DOY_W-1:0]   edoy_ff;
   logic [MON_W-1:0]   month_ff;
   logic [DAY_W-1:0]   rsp_day_ff;
   logic [MON_W-1:0]   rsp_month_ff;
   logic [YEAR_W-1:0]  rsp_year_ff;

   logic               leap;
   logic [RES_W-1:0]   sub_val;
   logic [RES_W-1:0]   res_bump;
   logic [DOY_W-1:0]   ylen;
   logic [DOY_W-1:0]   rest;
   logic [DOY_W-1:0]   doy_sum;
   logic [DOY_W-1:0]   mlen;

   // leap flag and year length from the residue
   assign leap = leap_res(res_ff[DOY_W-1:0]);
   assign ylen = year_len(leap);

   // one restoring step of year mod 400
   assign sub_val  = RES_W'(YEAR_CYCLE) << cmd.shift;
   // residue follows the working year as it advances
   assign res_bump = (res_ff == RES_W'(YEAR_CYCLE - 1)) ? '0 : res_ff + RES_W'(1);

   // day of year of the start date
   assign doy_sum = DOY_W'(day_ff) + days_before(mon_ff)
                    + DOY_W'((mon_ff > MONTH_FEB) && leap);

   // days left in the start year
   assign rest = ylen - doy_ff;

   assign mlen = month_len(month_ff, leap);

   // status back to the controller
   always_comb begin
      sts.fits_year  = (add_ff <= ADD_W'(rest));
      sts.past_year  = (add_ff > ADD_W'(ylen));
      sts.month_done = (edoy_ff <= mlen) || (month_ff == MONTH_DEC);
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff   <= start_day;
         mon_ff   <= start_month;
         add_ff   <= days_to_add;
         year_ff  <= EYEAR_W'(start_year);
         res_ff   <= start_year;
         month_ff <= MONTH_JAN;
      end
      if (cmd.reduce && (res_ff >= sub_val)) begin
         res_ff <= res_ff - sub_val;
      end
      if (cmd.calc_doy) begin
         doy_ff <= doy_sum;
      end
      if (cmd.span) begin
         if (sts.fits_year) begin
            edoy_ff <= doy_ff + add_ff[DOY_W-1:0];
         end else begin
            add_ff  <= add_ff - ADD_W'(rest);
            year_ff <= year_ff + EYEAR_W'(1);
            res_ff  <= res_bump;
         end
      end
      if (cmd.year_step) begin
         if (sts.past_year) begin
            add_ff  <= add_ff - ADD_W'(ylen);
            year_ff <= year_ff + EYEAR_W'(1);
            res_ff  <= res_bump;
         end else begin
            edoy_ff <= add_ff[DOY_W-1:0];
         end
      end
      // peel off one month; december never advances further
      if (cmd.month_step && (edoy_ff > mlen)) begin
         edoy_ff <= edoy_ff - mlen;
         if (month_ff != MONTH_DEC) begin
            month_ff <= month_ff + MON_W'(1);
         end
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_day_ff   <= edoy_ff[DAY_W-1:0];
         rsp_month_ff <= month_ff;
         rsp_year_ff  <= year_ff[YEAR_W-1:0];
      end
   end

   assign end_day   = rsp_day_ff;
   assign end_month = rsp_month_ff;
   assign end_year  = rsp_year_ff;

   // residue is fully reduced before it is used for leap tests
   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_doy |-> (res_ff < RES_W'(YEAR_CYCLE)))
      else $error("year residue not reduced");

   // start day of year never exceeds the year length
   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      cmd.span |-> (doy_ff <= ylen))
      else $error("day of year past year end");

   // month walk stays inside the year
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> ((month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC)
                          && (edoy_ff <= DOY_W'(366))))
      else $error("month walk out of range");

endmodule

`default_nettype wire
